// ----- src/feature_statistics_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the feature statistics accumulator checks.
// They use the clk and rst_n names of the module that expands them.
// ----------------------------------------------------------------------------
`ifndef FEATURE_STATISTICS_ACCUMULATOR_MACROS_SVH
`define FEATURE_STATISTICS_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define FSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsa check failed");

// next-cycle implication
`define FSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsa check failed");

`endif

// ----- src/fsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, widths and defaults of the feature statistics accumulator.
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int DEF_NUM_CLASSES  = 64;
    localparam int DEF_NUM_FEATURES = 256;
    localparam int DEF_MAX_COUNT    = 1023;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int VAL_W     = 17;
    localparam int CLAMP_W   = 25;
    localparam int CNT_OUT_W = 10;
    localparam int N_W       = 16;
    localparam int SUM_W     = 26;
    localparam int SQ_W      = 42;
    localparam int SQ_HALF_W = 21;
    localparam int DIV_W     = 58;
    localparam int DVS_W     = 32;
    localparam int ROOT_W    = 29;
    localparam int IT_W      = 6;
    localparam int MIN_COUNT = 2;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_EOR  = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_ADD_WR,
        OP_CNT_WR,
        OP_MEAN_INIT,
        OP_DIV_STEP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIFF,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic    clear_last;
        logic    iter_last;
        logic    cls_ok;
        logic    idx_ok;
        logic    cnt_ge2;
        logic    var_pos;
        logic    out_free;
        action_t act;
    } dp_stat_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [VAL_W-1:0] mn;
        logic [VAL_W-1:0] mx;
    } entry_t;

    function automatic logic [VAL_W-1:0] sat17(input logic [ROOT_W-1:0] v);
        logic [ROOT_W-1:0] lim;
        lim = ROOT_W'({VAL_W{1'b1}});
        return (v > lim) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
    endfunction

endpackage

// ----- src/fsa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_datapath
// Statistic memories, update logic, shared divider, square root, result regs.
// ----------------------------------------------------------------------------
module fsa_datapath #(
    parameter int NUM_CLASSES  = fsa_pkg::DEF_NUM_CLASSES,
    parameter int NUM_FEATURES = fsa_pkg::DEF_NUM_FEATURES,
    parameter int MAX_COUNT    = fsa_pkg::DEF_MAX_COUNT,
    parameter int FRAC_BITS    = fsa_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fsa_pkg::dp_cmd_t                 cmd,
    output fsa_pkg::dp_stat_t                stat,
    input  logic [1:0]                       action,
    input  logic [5:0]                       class_id,
    input  logic [7:0]                       feature,
    input  logic [fsa_pkg::VAL_W-1:0]        sample_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fsa_pkg::VAL_W-1:0]        mean_value,
    output logic [fsa_pkg::VAL_W-1:0]        std_dev,
    output logic [fsa_pkg::VAL_W-1:0]        min_value,
    output logic [fsa_pkg::VAL_W-1:0]        max_value,
    output logic [fsa_pkg::CNT_OUT_W-1:0]    count_out,
    output logic                             stats_valid
);
    import fsa_pkg::*;

    localparam int ENTRIES = NUM_CLASSES * NUM_FEATURES;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int CNT_W   = $clog2(MAX_COUNT + 1);
    localparam logic [CLAMP_W-1:0] ONE_EXT = CLAMP_W'(64'd1 << FRAC_BITS);
    localparam logic [ADDR_W-1:0]  LAST_IDX = ADDR_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_COUNT);

    entry_t           entry_mem [ENTRIES];
    logic [CNT_W-1:0] count_mem [NUM_CLASSES];

    // input decode
    logic              cls_ok, feat_ok, idx_ok;
    logic [ADDR_W-1:0] idx;
    logic [CLS_W-1:0]  cls_addr;
    logic [VAL_W-1:0]  val_clamped;

    assign cls_ok   = 32'(class_id) < NUM_CLASSES;
    assign feat_ok  = 32'(feature) < NUM_FEATURES;
    assign idx_ok   = cls_ok && feat_ok;
    assign idx      = idx_ok ? ADDR_W'(32'(class_id) * NUM_FEATURES + 32'(feature)) : '0;
    assign cls_addr = cls_ok ? CLS_W'(class_id) : '0;
    assign val_clamped = (CLAMP_W'(sample_value) > ONE_EXT) ? VAL_W'(ONE_EXT) : sample_value;

    // captured item
    action_t           act_reg;
    logic              cls_ok_reg, idx_ok_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [CLS_W-1:0]  cls_addr_reg;
    logic [VAL_W-1:0]  val_reg;
    entry_t            ent_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    // clear sweep
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;

    // arithmetic state
    logic [DIV_W-1:0]   dvd_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   sq_src_reg;
    logic [DVS_W-1:0]   srem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [IT_W-1:0]    it_cnt_reg, it_cnt_next;
    logic [IT_W-1:0]    it_lim_reg, it_lim_next;
    logic [36:0]        plo_reg;
    logic [2*SUM_W-1:0] bsq_reg;
    logic [DVS_W-1:0]   nn_reg;
    logic [DIV_W-1:0]   a_reg;
    logic               pos_reg;
    logic [VAL_W-1:0]   mean_reg;
    logic               out_valid_reg, out_valid_next;

    logic [N_W-1:0] n16;
    logic           ge2;
    assign n16 = N_W'(cnt_rd_reg);
    assign ge2 = n16 >= N_W'(MIN_COUNT);

    // add update
    logic [SUM_W:0]     sum_ext;
    logic [2*VAL_W-1:0] val_sq;
    logic [SQ_W:0]      sq_ext;
    entry_t             ent_upd;

    always_comb
    begin
        sum_ext = {1'b0, ent_rd_reg.sum} + (SUM_W+1)'(val_reg);
        val_sq  = val_reg * val_reg;
        sq_ext  = {1'b0, ent_rd_reg.sq} + (SQ_W+1)'(val_sq);
        ent_upd.sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        ent_upd.sq  = sq_ext[SQ_W] ? {SQ_W{1'b1}} : sq_ext[SQ_W-1:0];
        ent_upd.mn  = (val_reg < ent_rd_reg.mn) ? val_reg : ent_rd_reg.mn;
        ent_upd.mx  = (val_reg > ent_rd_reg.mx) ? val_reg : ent_rd_reg.mx;
    end

    // memory write ports
    logic              ent_we, cnt_we;
    logic [ADDR_W-1:0] ent_wa;
    logic [CLS_W-1:0]  cnt_wa;
    entry_t            ent_wd;
    logic [CNT_W-1:0]  cnt_wd;

    always_comb
    begin
        ent_we = 1'b0;
        cnt_we = 1'b0;
        ent_wa = idx_reg;
        cnt_wa = cls_addr_reg;
        ent_wd = ent_upd;
        cnt_wd = (cnt_rd_reg < CNT_MAX) ? cnt_rd_reg + CNT_W'(1) : cnt_rd_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                ent_we = 1'b1;
                ent_wa = clr_idx_reg;
                ent_wd = '{sum: '0, sq: '0, mn: {VAL_W{1'b1}}, mx: '0};
                cnt_we = 32'(clr_idx_reg) < NUM_CLASSES;
                cnt_wa = CLS_W'(clr_idx_reg);
                cnt_wd = '0;
            end
            OP_ADD_WR: ent_we = 1'b1;
            OP_CNT_WR: cnt_we = 1'b1;
            default:   ent_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            entry_mem[ent_wa] <= ent_wd;
        if (cmd.op == OP_CAPTURE)
            ent_rd_reg <= entry_mem[idx];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            count_mem[cnt_wa] <= cnt_wd;
        if (cmd.op == OP_CAPTURE)
            cnt_rd_reg <= count_mem[cls_addr];
    end

    // divider step (restoring, one quotient bit per cycle)
    logic [DVS_W:0] rem_sh;
    logic           q_bit;
    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign q_bit  = rem_sh >= {1'b0, dvs_reg};

    // square root step (two radicand bits per cycle)
    logic [DVS_W-1:0] srem_sh, trial;
    logic             r_bit;
    assign srem_sh = {srem_reg[DVS_W-3:0], sq_src_reg[DIV_W-1 -: 2]};
    assign trial   = DVS_W'({root_reg, 2'b01});
    assign r_bit   = srem_sh >= trial;

    logic [36:0]      phi;
    logic [DIV_W-1:0] a_sum;
    assign phi   = n16 * ent_rd_reg.sq[SQ_W-1:SQ_HALF_W];
    assign a_sum = {phi, {SQ_HALF_W{1'b0}}} + DIV_W'(plo_reg);

    always_comb
    begin
        clr_idx_next = clr_idx_reg;
        it_cnt_next  = it_cnt_reg;
        it_lim_next  = it_lim_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.op)
            OP_CLEAR:     clr_idx_next = clr_idx_reg + ADDR_W'(1);
            OP_MEAN_INIT:
            begin
                it_cnt_next = '0;
                it_lim_next = IT_W'(SUM_W - 1);
            end
            OP_DIFF:
            begin
                it_cnt_next = '0;
                it_lim_next = IT_W'(DIV_W - 1);
            end
            OP_SQRT_INIT:
            begin
                it_cnt_next = '0;
                it_lim_next = IT_W'(ROOT_W - 1);
            end
            OP_DIV_STEP,
            OP_SQRT_STEP: it_cnt_next = it_cnt_reg + IT_W'(1);
            OP_RESULT:    out_valid_next = 1'b1;
            default:      it_cnt_next = it_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg   <= '0;
            it_cnt_reg    <= '0;
            it_lim_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_idx_reg   <= clr_idx_next;
            it_cnt_reg    <= it_cnt_next;
            it_lim_reg    <= it_lim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                act_reg      <= action_t'(action);
                cls_ok_reg   <= cls_ok;
                idx_ok_reg   <= idx_ok;
                idx_reg      <= idx;
                cls_addr_reg <= cls_addr;
                val_reg      <= val_clamped;
                pos_reg      <= 1'b0;
                mean_reg     <= '0;
            end
            OP_MEAN_INIT:
            begin
                dvd_reg <= {ent_rd_reg.sum, {(DIV_W-SUM_W){1'b0}}};
                dvs_reg <= DVS_W'(n16);
                rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[DIV_W-2:0], q_bit};
                rem_reg <= q_bit ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
            end
            OP_MUL_LO:
            begin
                mean_reg <= sat17(ROOT_W'(dvd_reg[SUM_W-1:0]));
                plo_reg  <= n16 * ent_rd_reg.sq[SQ_HALF_W-1:0];
                bsq_reg  <= ent_rd_reg.sum * ent_rd_reg.sum;
                nn_reg   <= n16 * (n16 - N_W'(1));
            end
            OP_MUL_HI: a_reg <= a_sum;
            OP_DIFF:
            begin
                pos_reg <= a_reg > DIV_W'(bsq_reg);
                dvd_reg <= a_reg - DIV_W'(bsq_reg);
                dvs_reg <= nn_reg;
                rem_reg <= '0;
            end
            OP_SQRT_INIT:
            begin
                sq_src_reg <= dvd_reg;
                srem_reg   <= '0;
                root_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                sq_src_reg <= {sq_src_reg[DIV_W-3:0], 2'b00};
                srem_reg   <= r_bit ? srem_sh - trial : srem_sh;
                root_reg   <= {root_reg[ROOT_W-2:0], r_bit};
            end
            OP_RESULT:
            begin
                if (idx_ok_reg)
                begin
                    mean_value  <= mean_reg;
                    std_dev     <= pos_reg ? sat17(root_reg) : '0;
                    min_value   <= ent_rd_reg.mn;
                    max_value   <= ent_rd_reg.mx;
                    count_out   <= n16[CNT_OUT_W-1:0];
                    stats_valid <= ge2;
                end
                else
                begin
                    mean_value  <= '0;
                    std_dev     <= '0;
                    min_value   <= '0;
                    max_value   <= '0;
                    count_out   <= '0;
                    stats_valid <= 1'b0;
                end
            end
            default: mean_reg <= mean_reg;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign stat.clear_last = clr_idx_reg == LAST_IDX;
    assign stat.iter_last  = it_cnt_reg == it_lim_reg;
    assign stat.cls_ok     = cls_ok_reg;
    assign stat.idx_ok     = idx_ok_reg;
    assign stat.cnt_ge2    = ge2;
    assign stat.var_pos    = pos_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.act        = act_reg;

endmodule

// ----- src/fsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_ctrl
// Sequencer: clear sweep, item dispatch, mean/variance/root steps, result.
// ----------------------------------------------------------------------------
module fsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output fsa_pkg::dp_cmd_t  cmd,
    input  fsa_pkg::dp_stat_t stat
);
    import fsa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR     = 11'b00000000001,
        S_IDLE      = 11'b00000000010,
        S_DISPATCH  = 11'b00000000100,
        S_MEAN_DIV  = 11'b00000001000,
        S_MUL_LO    = 11'b00000010000,
        S_MUL_HI    = 11'b00000100000,
        S_DIFF      = 11'b00001000000,
        S_VAR_DIV   = 11'b00010000000,
        S_SQRT_INIT = 11'b00100000000,
        S_SQRT      = 11'b01000000000,
        S_RESULT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                case (stat.act)
                    ACT_ADD:
                        if (stat.idx_ok)
                            cmd.op = OP_ADD_WR;
                    ACT_EOR:
                        if (stat.cls_ok)
                            cmd.op = OP_CNT_WR;
                    ACT_READ:
                    begin
                        if (stat.idx_ok && stat.cnt_ge2)
                        begin
                            cmd.op     = OP_MEAN_INIT;
                            state_next = S_MEAN_DIV;
                        end
                        else
                            state_next = S_RESULT;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_MEAN_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.iter_last)
                    state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_VAR_DIV;
            end
            S_VAR_DIV:
            begin
                if (!stat.var_pos)
                    state_next = S_RESULT;
                else
                begin
                    cmd.op = OP_DIV_STEP;
                    if (stat.iter_last)
                        state_next = S_SQRT_INIT;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                if (stat.iter_last)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/feature_statistics_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_statistics_accumulator
// Per-class, per-feature running sum / sum of squares / min / max table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: action, class_id,
//   feature, sample_value. Add items update one table entry, end-of-record
//   items bump the class count (saturating), read items return one result.
//   Output channel (out_valid/out_ready) carries the read result: mean,
//   sample std deviation, min, max, count and stats_valid.
// Timing:
//   One item is in flight at a time. Add and end-of-record items read the
//   memory, then write back. A read whose count is below two goes straight
//   to the result load; one whose variance is not positive skips the variance
//   divide and the root. Otherwise: capture and dispatch, 26 mean divide steps,
//   3 multiply and subtract steps, 58 variance divide steps, 1 root setup, 29
//   square root steps, result load. The one-bit-per-cycle divider is shared.
// Reset:
//   After rst_n releases, a clearing pass writes every table entry, one per
//   cycle (NUM_CLASSES*NUM_FEATURES entries, 16384 by default); in_ready is
//   low until it ends.
// Stall:
//   A result sits in the output register until taken; add and end-of-record
//   items keep flowing meanwhile, and the next read waits only at its end.
// ----------------------------------------------------------------------------
module feature_statistics_accumulator #(
    parameter int NUM_CLASSES  = fsa_pkg::DEF_NUM_CLASSES,
    parameter int NUM_FEATURES = fsa_pkg::DEF_NUM_FEATURES,
    parameter int MAX_COUNT    = fsa_pkg::DEF_MAX_COUNT,
    parameter int FRAC_BITS    = fsa_pkg::DEF_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [5:0]                    class_id,
    input  logic [7:0]                    feature,
    input  logic [fsa_pkg::VAL_W-1:0]     sample_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fsa_pkg::VAL_W-1:0]     mean_value,
    output logic [fsa_pkg::VAL_W-1:0]     std_dev,
    output logic [fsa_pkg::VAL_W-1:0]     min_value,
    output logic [fsa_pkg::VAL_W-1:0]     max_value,
    output logic [fsa_pkg::CNT_OUT_W-1:0] count_out,
    output logic                          stats_valid
);
    import fsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: owns the only handshake decision on the input side
    fsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // tables, arithmetic and the output register
    fsa_datapath #(
        .NUM_CLASSES  (NUM_CLASSES),
        .NUM_FEATURES (NUM_FEATURES),
        .MAX_COUNT    (MAX_COUNT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .class_id     (class_id),
        .feature      (feature),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mean_value   (mean_value),
        .std_dev      (std_dev),
        .min_value    (min_value),
        .max_value    (max_value),
        .count_out    (count_out),
        .stats_valid  (stats_valid)
    );

endmodule

// ----- src/fsa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks of the feature statistics accumulator, bound to the top.
// ----------------------------------------------------------------------------
`include "feature_statistics_accumulator_macros.svh"

module fsa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [1:0]                    action,
    input logic [5:0]                    class_id,
    input logic [7:0]                    feature,
    input logic [fsa_pkg::VAL_W-1:0]     sample_value,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fsa_pkg::VAL_W-1:0]     mean_value,
    input logic [fsa_pkg::VAL_W-1:0]     std_dev,
    input logic [fsa_pkg::VAL_W-1:0]     min_value,
    input logic [fsa_pkg::VAL_W-1:0]     max_value,
    input logic [fsa_pkg::CNT_OUT_W-1:0] count_out,
    input logic                          stats_valid
);

    // a stalled result holds
    `FSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(mean_value) && $stable(std_dev) && $stable(count_out))

    // one item at a time: an accepted item keeps the input closed next cycle
    `FSA_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)

    // no statistics without at least two records
    `FSA_ASSERT_IMP(a_zero_invalid, out_valid && !stats_valid,
        mean_value == '0 && std_dev == '0)

endmodule

bind feature_statistics_accumulator fsa_checker u_fsa_checker (.*);

// ----- test/feature_statistics_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_statistics_accumulator_test
// Self-checking bench: a local copy of the statistics table predicts each
// read, and every returned statistic is compared field by field.
// ----------------------------------------------------------------------------
module feature_statistics_accumulator_test;
    import fsa_pkg::*;

    localparam int N_CLS    = 64;
    localparam int N_FEAT   = 256;
    localparam int CNT_CAP  = 1023;
    localparam int ONE_Q16  = 65536;
    localparam int CYC_LIMIT = 2000000;

    typedef struct packed {
        logic [VAL_W-1:0]     mean;
        logic [VAL_W-1:0]     sd;
        logic [VAL_W-1:0]     mn;
        logic [VAL_W-1:0]     mx;
        logic [CNT_OUT_W-1:0] cnt;
        logic                 ok;
    } stats_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = ACT_ADD;
    logic [5:0] class_id = '0;
    logic [7:0] feature = '0;
    logic [VAL_W-1:0] sample_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [VAL_W-1:0] mean_value, std_dev, min_value, max_value;
    logic [CNT_OUT_W-1:0] count_out;
    logic stats_valid;

    feature_statistics_accumulator u_top (.*);

    always #6 clk = ~clk;

    // local copy of the table
    logic [SUM_W-1:0] sum_tab [N_CLS*N_FEAT];
    logic [SQ_W-1:0]  sq_tab  [N_CLS*N_FEAT];
    logic [VAL_W-1:0] min_tab [N_CLS*N_FEAT];
    logic [VAL_W-1:0] max_tab [N_CLS*N_FEAT];
    int unsigned      cls_cnt [N_CLS];

    stats_t pending_stats[$];
    int errors = 0;
    int reads_seen = 0;
    int items_sent = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;   // receiver holds off, flow control test
    bit recv_fast = 1'b0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // update the local table; push an expectation for reads
    task automatic predict_item(logic [1:0] act, logic [5:0] c, logic [7:0] f,
                                logic [VAL_W-1:0] v_in);
        int idx;
        longint unsigned v, s, q, n, a, b, mean, sd;
        stats_t e;
        idx = c * N_FEAT + f;
        v = (v_in > ONE_Q16) ? ONE_Q16 : v_in;   // clamp above 1.0
        case (act)
            ACT_ADD:
            begin
                s = sum_tab[idx] + v;
                q = sq_tab[idx] + v * v;
                sum_tab[idx] = (s > (64'd1 << SUM_W) - 1) ? '1 : s[SUM_W-1:0];
                sq_tab[idx]  = (q > (64'd1 << SQ_W) - 1) ? '1 : q[SQ_W-1:0];
                if (v > max_tab[idx]) max_tab[idx] = v[VAL_W-1:0];
                if (v < min_tab[idx]) min_tab[idx] = v[VAL_W-1:0];
            end
            ACT_EOR:
                if (cls_cnt[c] < CNT_CAP) cls_cnt[c]++;
            ACT_READ:
            begin
                n = cls_cnt[c];
                s = sum_tab[idx];
                q = sq_tab[idx];
                mean = 0;
                sd = 0;
                if (n >= 2)
                begin
                    a = n * q;
                    b = s * s;
                    mean = s / n;
                    if (a > b) sd = int_sqrt((a - b) / (n * (n - 1)));
                end
                e.mean = (mean > 131071) ? '1 : mean[VAL_W-1:0];
                e.sd   = (sd > 131071) ? '1 : sd[VAL_W-1:0];
                e.mn   = min_tab[idx];
                e.mx   = max_tab[idx];
                e.cnt  = n[CNT_OUT_W-1:0];
                e.ok   = (n >= 2);
                pending_stats.push_back(e);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("MISMATCH read %0d %s: got %0d, want %0d", reads_seen, what, got, want);
    endtask

    // one item, held until accepted, with a random gap before it unless no_gap is set;
    // valid stays up after acceptance so back-to-back items need no extra drive
    task automatic send_item(logic [1:0] act, logic [5:0] c, logic [7:0] f,
                             logic [VAL_W-1:0] v, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                          : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        class_id <= c;
        feature <= f;
        sample_value <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(act, c, f, v);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n && out_valid && out_ready)
        begin
            reads_seen++;
            if (pending_stats.size() == 0)
                report_mismatch("result with none pending", 1, 0);
            else
            begin
                e = pending_stats.pop_front();
                if (mean_value !== e.mean) report_mismatch("mean", mean_value, e.mean);
                if (std_dev !== e.sd)      report_mismatch("std", std_dev, e.sd);
                if (min_value !== e.mn)    report_mismatch("min", min_value, e.mn);
                if (max_value !== e.mx)    report_mismatch("max", max_value, e.mx);
                if (count_out !== e.cnt)   report_mismatch("count", count_out, e.cnt);
                if (stats_valid !== e.ok)  report_mismatch("valid", stats_valid, e.ok);
            end
        end
    end

    // receiver: random stalls, some long, none while the fast window is on
    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (recv_fast)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // extremes of fields, clamping, empty entries, zero variance, unused action
    task automatic test_directed();
        send_item(ACT_READ, 6'd0, 8'd0, '0);           // untouched entry
        send_item(ACT_ADD, 6'd0, 8'd0, 17'd0);
        send_item(ACT_ADD, 6'd0, 8'd0, 17'h1FFFF);     // clamps to 1.0
        send_item(ACT_ADD, 6'd0, 8'd0, 17'd65536);
        send_item(ACT_READ, 6'd0, 8'd0, '0);           // count below two
        send_item(ACT_EOR, 6'd0, 8'd0, '0);
        send_item(ACT_EOR, 6'd0, 8'd0, '0);
        send_item(ACT_READ, 6'd0, 8'd0, '0);
        send_item(ACT_ADD, 6'd63, 8'd255, 17'd12345);
        send_item(ACT_ADD, 6'd63, 8'd255, 17'd12345);  // zero variance
        send_item(ACT_EOR, 6'd63, 8'd255, '0);
        send_item(ACT_EOR, 6'd63, 8'd255, '0);
        send_item(ACT_READ, 6'd63, 8'd255, '0);
        send_item(2'd3, 6'd5, 8'd5, 17'd100);          // unused action
        send_item(ACT_READ, 6'd5, 8'd5, '0);
    endtask

    // drive one class to its count bound
    task automatic test_count_saturation();
        repeat (CNT_CAP + 3) send_item(ACT_EOR, 6'd1, 8'd0, '0, 1'b1);
        send_item(ACT_ADD, 6'd1, 8'd9, 17'd1);
        send_item(ACT_READ, 6'd1, 8'd9, '0);
        wait_drained();
    endtask

    // large values on a class at its count bound: widest products and quotients
    task automatic test_big_sums();
        repeat (30) send_item(ACT_ADD, 6'd1, 8'd7, 17'd65536, 1'b1);
        send_item(ACT_READ, 6'd1, 8'd7, '0);
        repeat (30) send_item(ACT_ADD, 6'd1, 8'd8, 17'($urandom_range(0, 131071)), 1'b1);
        send_item(ACT_READ, 6'd1, 8'd8, '0);
        wait_drained();
    endtask

    // receiver blocked while reads and adds keep coming
    task automatic test_backpressure();
        int k;
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 12; k++)
            begin
                send_item(ACT_ADD, 6'd2, k[7:0], 17'($urandom_range(0, 65536)), 1'b1);
                send_item(ACT_READ, 6'd2, k[7:0], '0, 1'b1);
            end
        join
        wait_drained();
    endtask

    // random records on a few classes/features, mostly well formed
    task automatic test_random(int n_items);
        int k, j;
        logic [5:0] c;
        logic [7:0] f;
        k = 0;
        recv_fast = 1'b0;
        while (k < n_items)
        begin
            c = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(3, 6));
            if ($urandom_range(0, 9) == 0)
            begin
                // noise item
                send_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)), 17'($urandom_range(0, 131071)));
                k++;
            end
            else
            begin
                // a record: add several features, end it, maybe read
                for (j = 0; j < $urandom_range(1, 6); j++)
                begin
                    f = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 3));
                    send_item(ACT_ADD, c, f, ($urandom_range(0, 7) == 0) ?
                              17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 65536)));
                    k++;
                end
                send_item(ACT_EOR, c, 8'($urandom_range(0, 255)),
                          17'($urandom_range(0, 131071)));
                k++;
                if ($urandom_range(0, 2) == 0)
                begin
                    send_item(ACT_READ, c, 8'($urandom_range(0, 3)),
                              17'($urandom_range(0, 131071)));
                    k++;
                end
            end
            if (k > n_items / 2 && k < n_items / 2 + 10) recv_fast = 1'b1;
            else recv_fast = 1'b0;
        end
        wait_drained();
    endtask

    initial
    begin
        for (int k = 0; k < N_CLS * N_FEAT; k++)
        begin
            sum_tab[k] = '0;
            sq_tab[k] = '0;
            min_tab[k] = '1;
            max_tab[k] = '0;
        end
        for (int k = 0; k < N_CLS; k++) cls_cnt[k] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_count_saturation();
        test_big_sums();
        test_backpressure();
        test_random(200);
        repeat (200) @(posedge clk);
        $display("Covered %0d items and %0d reads: clamping, count bound, wide products,",
                 items_sent, reads_seen);
        $display("receiver hold-off and random records with gaps on both sides.");
        if (errors == 0 && pending_stats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/fsa_pkg.sv
src/fsa_datapath.sv
src/fsa_ctrl.sv
src/feature_statistics_accumulator.sv
src/fsa_checker.sv
test/feature_statistics_accumulator_test.sv
